// File: sv/spoly_pkg.sv
// Package for the sparse polynomial add/multiply block.
// Holds list depth, index widths, command and result codes, payload structs.
// No dependencies.
package spoly_pkg;

  localparam int MAX_TERMS = 8;
  localparam int CNT_W     = $clog2(MAX_TERMS + 1);
  localparam int IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

  localparam logic [2:0] CMD_APPEND_A = 3'd0;
  localparam logic [2:0] CMD_APPEND_B = 3'd1;
  localparam logic [2:0] CMD_CLEAR_A  = 3'd2;
  localparam logic [2:0] CMD_CLEAR_B  = 3'd3;
  localparam logic [2:0] CMD_ADD      = 3'd4;
  localparam logic [2:0] CMD_MUL      = 3'd5;

  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_FULL  = 2'd1;
  localparam logic [1:0] KIND_TERM  = 2'd2;
  localparam logic [1:0] KIND_EMPTY = 2'd3;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [15:0] term_coefficient;
    logic [9:0]         term_exponent;
  } in_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] out_coefficient;
    logic [10:0]        out_exponent;
    logic               last;
  } out_t;

  typedef struct packed {
    logic signed [15:0] coef;
    logic [9:0]         expo;
  } term_t;

endpackage

// File: sv/spoly_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module spoly_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/sparse_polynomial_add_multiply.sv
// Top level of the sparse polynomial add/multiply block.
// Depends on spoly_pkg and spoly_ram.
//
// Usage:
//   in_valid/in_ready/in_data carry one command per transaction: append a
//   term to list A or B, clear a list, add, or multiply. out_valid/out_ready/
//   out_data return the results; the final result of a command has last set.
//   Append and clear give one acknowledge (kind full when the list already
//   holds MAX_TERMS terms). Commands 6 and 7 are taken and give nothing.
//   Timing: the result of a load, clear or empty answer is valid the cycle
//   after acceptance. Add and multiply read both term RAMs (registered read
//   data) and then put out one term per cycle while the receiver accepts, the
//   first one behind the RAM read and the output register; add takes up to
//   a_count + b_count terms, multiply a_count * b_count terms.
//   Loads and clears are taken every cycle while the output register can
//   accept. During add or multiply in_ready is low until the last term is
//   loaded into the output register.
//   A stalled receiver holds the output register, and the term walk waits
//   with it. Reset empties both lists and the output register; RAM contents
//   are not cleared, as only entries below the counts are read.
module sparse_polynomial_add_multiply
  import spoly_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ADD  = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] a_cnt_r, a_cnt_nxt, b_cnt_r, b_cnt_nxt;
  logic [CNT_W-1:0] i_r, i_nxt, j_r, j_nxt;
  logic             out_valid_r;
  out_t             out_data_r, res;
  logic             emit, out_free;
  logic             a_we, b_we;
  term_t            wterm, a_rd, b_rd;
  logic             a_take, b_take;
  logic signed [31:0] prod;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign wterm.coef = in_data.term_coefficient;
  assign wterm.expo = in_data.term_exponent;

  assign a_take = (i_r < a_cnt_r);
  assign b_take = (j_r < b_cnt_r);
  assign prod   = a_rd.coef * b_rd.coef;

  spoly_ram #(.WIDTH($bits(term_t)), .DEPTH(MAX_TERMS)) u_ram_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_cnt_r[IDX_W-1:0]),
    .wdata (wterm),
    .raddr (i_nxt[IDX_W-1:0]),
    .rdata (a_rd)
  );

  spoly_ram #(.WIDTH($bits(term_t)), .DEPTH(MAX_TERMS)) u_ram_b (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_cnt_r[IDX_W-1:0]),
    .wdata (wterm),
    .raddr (j_nxt[IDX_W-1:0]),
    .rdata (b_rd)
  );

  always_comb begin
    state_nxt = state_r;
    a_cnt_nxt = a_cnt_r;
    b_cnt_nxt = b_cnt_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    emit      = 1'b0;
    a_we      = 1'b0;
    b_we      = 1'b0;
    res       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          i_nxt    = '0;
          j_nxt    = '0;
          res.last = 1'b1;
          res.kind = KIND_ACK;
          case (in_data.command)
            CMD_APPEND_A: begin
              emit = 1'b1;
              if (a_cnt_r < CNT_W'(MAX_TERMS)) begin
                a_we      = 1'b1;
                a_cnt_nxt = a_cnt_r + CNT_W'(1);
              end else begin
                res.kind = KIND_FULL;
              end
            end
            CMD_APPEND_B: begin
              emit = 1'b1;
              if (b_cnt_r < CNT_W'(MAX_TERMS)) begin
                b_we      = 1'b1;
                b_cnt_nxt = b_cnt_r + CNT_W'(1);
              end else begin
                res.kind = KIND_FULL;
              end
            end
            CMD_CLEAR_A: begin
              emit      = 1'b1;
              a_cnt_nxt = '0;
            end
            CMD_CLEAR_B: begin
              emit      = 1'b1;
              b_cnt_nxt = '0;
            end
            CMD_ADD: begin
              if (a_cnt_r == '0 && b_cnt_r == '0) begin
                emit     = 1'b1;
                res.kind = KIND_EMPTY;
              end else begin
                state_nxt = ST_ADD;
              end
            end
            CMD_MUL: begin
              if (a_cnt_r == '0 || b_cnt_r == '0) begin
                emit     = 1'b1;
                res.kind = KIND_EMPTY;
              end else begin
                state_nxt = ST_MUL;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_ADD: begin
        if (out_free) begin
          emit     = 1'b1;
          res.kind = KIND_TERM;
          if (a_take && b_take && (a_rd.expo == b_rd.expo)) begin
            res.out_coefficient = 32'(a_rd.coef) + 32'(b_rd.coef);
            res.out_exponent    = 11'(a_rd.expo);
            i_nxt               = i_r + CNT_W'(1);
            j_nxt               = j_r + CNT_W'(1);
          end else if (a_take && (!b_take || (a_rd.expo > b_rd.expo))) begin
            res.out_coefficient = 32'(a_rd.coef);
            res.out_exponent    = 11'(a_rd.expo);
            i_nxt               = i_r + CNT_W'(1);
          end else begin
            res.out_coefficient = 32'(b_rd.coef);
            res.out_exponent    = 11'(b_rd.expo);
            j_nxt               = j_r + CNT_W'(1);
          end
          res.last = (i_nxt == a_cnt_r) && (j_nxt == b_cnt_r);
          if (res.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_MUL: begin
        if (out_free) begin
          emit                = 1'b1;
          res.kind            = KIND_TERM;
          res.out_coefficient = prod;
          res.out_exponent    = {1'b0, a_rd.expo} + {1'b0, b_rd.expo};
          if (j_r == b_cnt_r - CNT_W'(1)) begin
            j_nxt = '0;
            i_nxt = i_r + CNT_W'(1);
          end else begin
            j_nxt = j_r + CNT_W'(1);
          end
          res.last = (i_r == a_cnt_r - CNT_W'(1)) && (j_r == b_cnt_r - CNT_W'(1));
          if (res.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      a_cnt_r     <= '0;
      b_cnt_r     <= '0;
      i_r         <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      a_cnt_r <= a_cnt_nxt;
      b_cnt_r <= b_cnt_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= res;
    end
  end

endmodule

// File: sv/spoly_checker.sv
// Port-level checker for sparse_polynomial_add_multiply, with its bind.
// Depends on spoly_pkg.
module spoly_checker
  import spoly_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input in_t  in_data,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result transaction changed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_load_ack: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready &&
    (in_data.command == CMD_APPEND_A || in_data.command == CMD_APPEND_B ||
     in_data.command == CMD_CLEAR_A || in_data.command == CMD_CLEAR_B)
    |=> out_valid && out_data.last &&
        (out_data.kind == KIND_ACK || out_data.kind == KIND_FULL))
    else $error("load or clear not acknowledged");

  a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_EMPTY
    |-> out_data.last && out_data.out_coefficient == 0 && out_data.out_exponent == 0)
    else $error("malformed empty result");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> !in_ready)
    else $error("input taken in the middle of a result sequence");

endmodule

bind sparse_polynomial_add_multiply spoly_checker u_spoly_checker (.*);

// File: verif/sparse_polynomial_add_multiply_tb.sv
// Testbench for sparse_polynomial_add_multiply: directed and random command traffic with
// random stalls on both channels; every result is checked against a local list model.
// Depends on spoly_pkg and the block's RTL.
`timescale 1ns / 1ps

module sparse_polynomial_add_multiply_tb;
  import spoly_pkg::*;

  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  sparse_polynomial_add_multiply dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // local copy of both term lists
  logic signed [15:0] poly_a_coef [MAX_TERMS];
  logic [9:0]         poly_a_expo [MAX_TERMS];
  logic signed [15:0] poly_b_coef [MAX_TERMS];
  logic [9:0]         poly_b_expo [MAX_TERMS];
  int poly_a_len = 0;
  int poly_b_len = 0;

  out_t pending_results[$];
  int   errors = 0;
  int   commands_sent = 0;
  bit   in_stall_en = 1'b0;
  bit   out_stall_en = 1'b0;
  int   out_hold = 0;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 2);
    if (r < 19) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  function automatic void push_term(logic [1:0] k, logic signed [31:0] c, logic [10:0] e);
    out_t r;
    r.kind = k;
    r.out_coefficient = c;
    r.out_exponent = e;
    r.last = 1'b0;
    pending_results.push_back(r);
  endfunction

  function automatic void predict_results(in_t t);
    int   first;
    int   i;
    int   j;
    out_t r;
    first = pending_results.size();
    i = 0;
    j = 0;
    case (t.command)
      CMD_APPEND_A: begin
        if (poly_a_len >= MAX_TERMS) begin
          push_term(KIND_FULL, 0, 0);
        end else begin
          poly_a_coef[poly_a_len] = t.term_coefficient;
          poly_a_expo[poly_a_len] = t.term_exponent;
          poly_a_len++;
          push_term(KIND_ACK, 0, 0);
        end
      end
      CMD_APPEND_B: begin
        if (poly_b_len >= MAX_TERMS) begin
          push_term(KIND_FULL, 0, 0);
        end else begin
          poly_b_coef[poly_b_len] = t.term_coefficient;
          poly_b_expo[poly_b_len] = t.term_exponent;
          poly_b_len++;
          push_term(KIND_ACK, 0, 0);
        end
      end
      CMD_CLEAR_A: begin
        poly_a_len = 0;
        push_term(KIND_ACK, 0, 0);
      end
      CMD_CLEAR_B: begin
        poly_b_len = 0;
        push_term(KIND_ACK, 0, 0);
      end
      CMD_ADD: begin
        while (i < poly_a_len && j < poly_b_len) begin
          if (poly_a_expo[i] == poly_b_expo[j]) begin
            push_term(KIND_TERM, int'(poly_a_coef[i]) + int'(poly_b_coef[j]),
                      11'(poly_a_expo[i]));
            i++;
            j++;
          end else if (poly_a_expo[i] > poly_b_expo[j]) begin
            push_term(KIND_TERM, int'(poly_a_coef[i]), 11'(poly_a_expo[i]));
            i++;
          end else begin
            push_term(KIND_TERM, int'(poly_b_coef[j]), 11'(poly_b_expo[j]));
            j++;
          end
        end
        for (; j < poly_b_len; j++)
          push_term(KIND_TERM, int'(poly_b_coef[j]), 11'(poly_b_expo[j]));
        for (; i < poly_a_len; i++)
          push_term(KIND_TERM, int'(poly_a_coef[i]), 11'(poly_a_expo[i]));
      end
      CMD_MUL: begin
        for (i = 0; i < poly_a_len; i++)
          for (j = 0; j < poly_b_len; j++)
            push_term(KIND_TERM, int'(poly_a_coef[i]) * int'(poly_b_coef[j]),
                      11'(poly_a_expo[i]) + 11'(poly_b_expo[j]));
      end
      default: return;
    endcase
    if (pending_results.size() == first) push_term(KIND_EMPTY, 0, 0);
    r = pending_results.pop_back();
    r.last = 1'b1;
    pending_results.push_back(r);
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report("unexpected transaction", 32'(out_data.kind), 0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.kind !== want.kind)
          report("kind", 32'(out_data.kind), 32'(want.kind));
        if (out_data.out_coefficient !== want.out_coefficient)
          report("coefficient", out_data.out_coefficient, want.out_coefficient);
        if (out_data.out_exponent !== want.out_exponent)
          report("exponent", 32'(out_data.out_exponent), 32'(want.out_exponent));
        if (out_data.last !== want.last)
          report("last", 32'(out_data.last), 32'(want.last));
      end
    end
  end

  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_ready <= 1'b0;
      out_hold <= out_hold - 1;
    end else if (out_stall_en && $urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      out_hold <= gap_len() - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic idle_in(int n);
    @(negedge clk);
    in_valid = 1'b0;
    in_data = in_t'($urandom);
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic send_cmd(logic [2:0] c, logic signed [15:0] coef, logic [9:0] expo);
    in_t t;
    t.command = c;
    t.term_coefficient = coef;
    t.term_exponent = expo;
    @(negedge clk);
    in_valid = 1'b1;
    in_data = t;
    do @(posedge clk); while (!in_ready);
    predict_results(t);
    if (c <= CMD_MUL) commands_sent++;
    if (in_stall_en && $urandom_range(0, 2) == 0) idle_in(gap_len());
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_coef();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int pick_len();
    if ($urandom_range(0, 6) != 0) return $urandom_range(0, 4);
    return $urandom_range(5, MAX_TERMS + 1);
  endfunction

  task automatic test_directed();
    send_cmd(CMD_CLEAR_A, 0, 0);
    send_cmd(CMD_CLEAR_B, 0, 0);
    send_cmd(CMD_ADD, 0, 0);
    send_cmd(CMD_MUL, 0, 0);
    send_cmd(CMD_SPARE_LO, 16'sh5a5a, 10'h155);
    send_cmd(CMD_SPARE_HI, 16'shffff, 10'h3ff);
    send_cmd(CMD_APPEND_A, 16'sh8000, 10'd1023);
    send_cmd(CMD_MUL, 0, 0);
    send_cmd(CMD_ADD, 0, 0);
    send_cmd(CMD_APPEND_A, 16'sh7fff, 10'd900);
    send_cmd(CMD_APPEND_A, 16'sd1234, 10'd700);
    send_cmd(CMD_APPEND_A, -16'sd1, 10'd500);
    send_cmd(CMD_APPEND_A, 16'sd0, 10'd300);
    send_cmd(CMD_APPEND_A, 16'sd9, 10'd200);
    send_cmd(CMD_APPEND_A, -16'sd7, 10'd100);
    send_cmd(CMD_APPEND_A, 16'sd2, 10'd0);
    send_cmd(CMD_APPEND_A, 16'sd55, 10'd50);
    send_cmd(CMD_APPEND_B, 16'sh8000, 10'd1023);
    send_cmd(CMD_APPEND_B, 16'sd5, 10'd800);
    send_cmd(CMD_APPEND_B, -16'sd1234, 10'd700);
    send_cmd(CMD_APPEND_B, 16'sh7fff, 10'd650);
    send_cmd(CMD_APPEND_B, 16'sd7, 10'd300);
    send_cmd(CMD_APPEND_B, 16'sd1, 10'd150);
    send_cmd(CMD_APPEND_B, -16'sd5, 10'd100);
    send_cmd(CMD_APPEND_B, 16'sd3, 10'd0);
    send_cmd(CMD_APPEND_B, 16'sd66, 10'd60);
    send_cmd(CMD_ADD, 0, 0);
    send_cmd(CMD_MUL, 0, 0);
  endtask

  // optionally clear, load two descending lists with random content, then optionally add and/or multiply
  task automatic send_polynomial_pair();
    int a_exps[$];
    int b_exps[$];
    int na;
    int nb;
    na = pick_len();
    nb = pick_len();
    for (int k = 0; k < na; k++) a_exps.push_back($urandom_range(0, 1023));
    for (int k = 0; k < nb; k++) begin
      if (na > 0 && $urandom_range(0, 1) == 0)
        b_exps.push_back(a_exps[$urandom_range(0, na - 1)]);
      else
        b_exps.push_back($urandom_range(0, 1023));
    end
    a_exps.rsort();
    b_exps.rsort();
    if ($urandom_range(0, 4) != 0) send_cmd(CMD_CLEAR_A, rand_coef(), 10'($urandom));
    if ($urandom_range(0, 4) != 0) send_cmd(CMD_CLEAR_B, rand_coef(), 10'($urandom));
    foreach (a_exps[k]) send_cmd(CMD_APPEND_A, rand_coef(), 10'(a_exps[k]));
    foreach (b_exps[k]) send_cmd(CMD_APPEND_B, rand_coef(), 10'(b_exps[k]));
    if ($urandom_range(0, 3) != 0) send_cmd(CMD_ADD, rand_coef(), 10'($urandom));
    if ($urandom_range(0, 3) != 0) send_cmd(CMD_MUL, rand_coef(), 10'($urandom));
  endtask

  task automatic test_random_traffic(int n);
    int start;
    start = commands_sent;
    while (commands_sent - start < n) begin
      if ($urandom_range(0, 9) < 8) begin
        send_polynomial_pair();
      end else begin
        repeat ($urandom_range(1, 6))
          send_cmd(3'($urandom_range(0, 7)), 16'($urandom), 10'($urandom));
      end
    end
  endtask

  task automatic test_pause_for_results();
    send_cmd(CMD_MUL, 0, 0);
    wait_drained();
    send_cmd(CMD_ADD, 0, 0);
    send_cmd(CMD_CLEAR_A, 0, 0);
    send_cmd(CMD_ADD, 0, 0);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    in_stall_en = 1'b1;
    out_stall_en = 1'b1;
    test_random_traffic(150);
    test_pause_for_results();
    in_stall_en = 1'b0;
    out_stall_en = 1'b0;
    test_random_traffic(70);
    out_stall_en = 1'b1;
    test_random_traffic(50);
    in_stall_en = 1'b1;
    out_stall_en = 1'b0;
    test_random_traffic(25);
    @(negedge clk);
    in_valid = 1'b0;
    wait_drained();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("FAILURE");
    $finish;
  end

endmodule
